// File: sv/pru_pkg.sv
// pru_pkg: types and fixed field widths shared by the page replacement unit.
// No dependencies; compiled first.
`default_nettype none

package pru_pkg;

  // Field widths of the transaction payloads
  localparam int PAGE_W  = 16;
  localparam int OWNER_W = 16;
  localparam int FRAME_W = 2;

  // Replacement policy codes (configuration register)
  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU  = 1'b1;

  typedef struct packed {
    logic [PAGE_W-1:0]  page_id;
    logic [OWNER_W-1:0] owner_id;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame_used;
    logic [OWNER_W-1:0] resident_owner;
    logic               evicted;
    logic [PAGE_W-1:0]  evicted_page;
    logic [OWNER_W-1:0] evicted_owner;
  } out_item_t;

  // Engine sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_FINISH = 5'b10000
  } eng_state_t;

endpackage

`default_nettype wire

// File: sv/pru_stream_if.sv
// pru_stream_if: valid/ready channel carrying one payload of type T.
// No dependencies; payload types come from pru_pkg at the instance.
`default_nettype none

interface pru_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/pru_ram.sv
// pru_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/pru_engine.sv
// pru_engine: frame table sequencer; walks the frame RAM once to look up the page and
// pick a free frame or victim, then, except on a FIFO-mode hit, once more to update age ranks.
// Depends on pru_pkg and pru_ram.
`default_nettype none

module pru_engine #(
  parameter int FRAMES    = 4,
  parameter int PAGE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  pru_pkg::in_item_t  item,
  input  logic               mode,
  output logic               idle,
  output logic               res_valid,
  output pru_pkg::out_item_t res,
  input  logic               res_ack
);

  localparam int IW      = $clog2(FRAMES);
  localparam int RW      = IW;
  localparam int OwnerW  = pru_pkg::OWNER_W;
  localparam int PageW   = pru_pkg::PAGE_W;
  localparam int FrameW  = pru_pkg::FRAME_W;
  localparam int EW      = PAGE_BITS + OwnerW + RW;
  localparam logic [IW:0]   FramesC = (IW+1)'(FRAMES);
  localparam logic [IW-1:0] LastIdx = IW'(FRAMES - 1);

  pru_pkg::eng_state_t state_r, state_nxt;

  logic [IW:0]           rd_cnt_r, rd_cnt_nxt;
  logic                  pv_r, pv_nxt;
  logic [IW-1:0]         pidx_r, pidx_nxt;
  logic [FRAMES-1:0]     valid_r, valid_nxt;

  logic [PAGE_BITS-1:0]  key_r, key_nxt;
  logic [OwnerW-1:0]     own_r, own_nxt;
  logic                  found_r, found_nxt;
  logic [IW-1:0]         hit_idx_r, hit_idx_nxt;
  logic [RW-1:0]         hit_rank_r, hit_rank_nxt;
  logic [OwnerW-1:0]     hit_owner_r, hit_owner_nxt;
  logic                  free_r, free_nxt;
  logic [IW-1:0]         free_idx_r, free_idx_nxt;
  logic [RW-1:0]         best_rank_r, best_rank_nxt;
  logic [IW-1:0]         best_idx_r, best_idx_nxt;
  logic [PAGE_BITS-1:0]  best_page_r, best_page_nxt;
  logic [OwnerW-1:0]     best_owner_r, best_owner_nxt;

  logic [IW-1:0]         tgt_r, tgt_nxt;
  logic [RW-1:0]         lim_r, lim_nxt;
  logic                  all_r, all_nxt;
  logic [OwnerW-1:0]     new_owner_r, new_owner_nxt;
  pru_pkg::out_item_t    res_r, res_nxt;

  logic                  ram_we;
  logic [EW-1:0]         ram_wdata;
  logic [EW-1:0]         ram_rdata;

  // Fields of the entry read last cycle
  logic [PAGE_BITS-1:0]  e_page;
  logic [OwnerW-1:0]     e_owner;
  logic [RW-1:0]         e_rank;
  logic                  e_valid;
  logic                  e_match;

  assign e_page  = ram_rdata[EW-1 -: PAGE_BITS];
  assign e_owner = ram_rdata[RW +: OwnerW];
  assign e_rank  = ram_rdata[RW-1:0];
  assign e_valid = valid_r[pidx_r];
  assign e_match = e_valid && (e_page == key_r);

  // Frame RAM: page, owner and age rank per frame
  pru_ram #(
    .WIDTH (EW),
    .DEPTH (FRAMES)
  ) u_frames (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pidx_r),
    .wdata (ram_wdata),
    .raddr (rd_cnt_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  // Sequencer and shared compare / rank update
  always_comb begin
    state_nxt      = state_r;
    rd_cnt_nxt     = rd_cnt_r;
    pv_nxt         = 1'b0;
    pidx_nxt       = pidx_r;
    valid_nxt      = valid_r;
    key_nxt        = key_r;
    own_nxt        = own_r;
    found_nxt      = found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_rank_nxt   = hit_rank_r;
    hit_owner_nxt  = hit_owner_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    best_rank_nxt  = best_rank_r;
    best_idx_nxt   = best_idx_r;
    best_page_nxt  = best_page_r;
    best_owner_nxt = best_owner_r;
    tgt_nxt        = tgt_r;
    lim_nxt        = lim_r;
    all_nxt        = all_r;
    new_owner_nxt  = new_owner_r;
    res_nxt        = res_r;
    ram_we         = 1'b0;
    ram_wdata      = {e_page, e_owner, e_rank + RW'(1)};

    case (state_r)
      pru_pkg::ST_IDLE: begin
        if (start) begin
          key_nxt       = PAGE_BITS'(item.page_id);
          own_nxt       = item.owner_id;
          found_nxt     = 1'b0;
          free_nxt      = 1'b0;
          best_rank_nxt = '0;
          best_idx_nxt  = '0;
          rd_cnt_nxt    = '0;
          state_nxt     = pru_pkg::ST_SCAN;
        end
      end

      pru_pkg::ST_SCAN: begin
        // issue the next frame read
        if (rd_cnt_r < FramesC) begin
          pv_nxt     = 1'b1;
          pidx_nxt   = rd_cnt_r[IW-1:0];
          rd_cnt_nxt = rd_cnt_r + (IW+1)'(1);
        end
        // examine the frame read last cycle
        if (pv_r) begin
          if (e_match && !found_r) begin
            found_nxt     = 1'b1;
            hit_idx_nxt   = pidx_r;
            hit_rank_nxt  = e_rank;
            hit_owner_nxt = e_owner;
          end
          if (!e_valid && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = pidx_r;
          end
          // victim candidate: frame 0 first, then any strictly older
          if (e_valid && ((pidx_r == '0) || (e_rank > best_rank_r))) begin
            best_rank_nxt  = e_rank;
            best_idx_nxt   = pidx_r;
            best_page_nxt  = e_page;
            best_owner_nxt = e_owner;
          end
          if (pidx_r == LastIdx) begin
            state_nxt = pru_pkg::ST_DECIDE;
          end
        end
      end

      pru_pkg::ST_DECIDE: begin
        rd_cnt_nxt            = '0;
        res_nxt.evicted       = 1'b0;
        res_nxt.evicted_page  = '0;
        res_nxt.evicted_owner = '0;
        all_nxt               = 1'b0;
        if (found_r) begin
          // hit: LRU promotes the frame, FIFO leaves order alone
          res_nxt.hit            = 1'b1;
          res_nxt.frame_used     = FrameW'(hit_idx_r);
          res_nxt.resident_owner = hit_owner_r;
          tgt_nxt                = hit_idx_r;
          lim_nxt                = hit_rank_r;
          new_owner_nxt          = hit_owner_r;
          state_nxt = (mode == pru_pkg::MODE_LRU) ? pru_pkg::ST_UPDATE
                                                  : pru_pkg::ST_FINISH;
        end else if (free_r) begin
          // fault into a free frame: all resident frames age
          res_nxt.hit            = 1'b0;
          res_nxt.frame_used     = FrameW'(free_idx_r);
          res_nxt.resident_owner = own_r;
          tgt_nxt                = free_idx_r;
          all_nxt                = 1'b1;
          new_owner_nxt          = own_r;
          state_nxt              = pru_pkg::ST_UPDATE;
        end else begin
          // fault with table full: replace the oldest frame
          res_nxt.hit            = 1'b0;
          res_nxt.frame_used     = FrameW'(best_idx_r);
          res_nxt.resident_owner = own_r;
          res_nxt.evicted        = 1'b1;
          res_nxt.evicted_page   = PageW'(best_page_r);
          res_nxt.evicted_owner  = best_owner_r;
          tgt_nxt                = best_idx_r;
          lim_nxt                = best_rank_r;
          new_owner_nxt          = own_r;
          state_nxt              = pru_pkg::ST_UPDATE;
        end
      end

      pru_pkg::ST_UPDATE: begin
        if (rd_cnt_r < FramesC) begin
          pv_nxt     = 1'b1;
          pidx_nxt   = rd_cnt_r[IW-1:0];
          rd_cnt_nxt = rd_cnt_r + (IW+1)'(1);
        end
        if (pv_r) begin
          if (pidx_r == tgt_r) begin
            // target frame: new or promoted entry at rank 0
            ram_we            = 1'b1;
            ram_wdata         = {key_r, new_owner_r, RW'(0)};
            valid_nxt[pidx_r] = 1'b1;
          end else if (e_valid && (all_r || (e_rank < lim_r))) begin
            ram_we = 1'b1;
          end
          if (pidx_r == LastIdx) begin
            state_nxt = pru_pkg::ST_FINISH;
          end
        end
      end

      pru_pkg::ST_FINISH: begin
        if (res_ack) begin
          state_nxt = pru_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = pru_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pru_pkg::ST_IDLE;
      rd_cnt_r <= '0;
      pv_r     <= 1'b0;
      valid_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      pv_r     <= pv_nxt;
      valid_r  <= valid_nxt;
    end
  end

  // Working registers and result
  always_ff @(posedge clk) begin
    pidx_r       <= pidx_nxt;
    key_r        <= key_nxt;
    own_r        <= own_nxt;
    found_r      <= found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_rank_r   <= hit_rank_nxt;
    hit_owner_r  <= hit_owner_nxt;
    free_r       <= free_nxt;
    free_idx_r   <= free_idx_nxt;
    best_rank_r  <= best_rank_nxt;
    best_idx_r   <= best_idx_nxt;
    best_page_r  <= best_page_nxt;
    best_owner_r <= best_owner_nxt;
    tgt_r        <= tgt_nxt;
    lim_r        <= lim_nxt;
    all_r        <= all_nxt;
    new_owner_r  <= new_owner_nxt;
    res_r        <= res_nxt;
  end

  assign idle      = (state_r == pru_pkg::ST_IDLE);
  assign res_valid = (state_r == pru_pkg::ST_FINISH);
  assign res       = res_r;

endmodule

`default_nettype wire

// File: sv/page_replacement_unit_top.sv
// page_replacement_unit_top: handshake, mode register and result register
// around the frame table engine. Depends on pru_pkg, pru_stream_if, pru_engine.
`default_nettype none

// Fully associative table of FRAMES page frames with FIFO or LRU replacement.
// Each input transaction is one page access (page_id, owner_id); each yields
// exactly one result transaction: hit flag, frame holding the page, owner in
// that frame, and on replacement the evicted page and owner. Page numbers are
// compared and stored in their low PAGE_BITS bits. replace_mode (cfg port,
// 0 = FIFO, 1 = LRU) may be written only while no access is in flight. The
// engine walks the single frame RAM read port once per access to look up
// the page, and once more to update the age ranks unless the access is a
// FIFO-mode hit. The next access is accepted only once the engine is idle
// again, which waits while the result register stays full. No clearing
// pass after reset is needed.
module page_replacement_unit_top #(
  parameter int FRAMES    = 4,
  parameter int PAGE_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  pru_stream_if.sink   in_if,
  pru_stream_if.source out_if,
  pru_stream_if.sink   cfg_if
);

  logic               mode_r;
  logic               out_valid_r, out_valid_nxt;
  pru_pkg::out_item_t out_data_r;

  logic               eng_idle;
  logic               eng_res_valid;
  pru_pkg::out_item_t eng_res;
  logic               eng_res_ack;
  logic               in_take;

  assign in_if.ready  = eng_idle;
  assign in_take      = in_if.valid && eng_idle;
  assign cfg_if.ready = 1'b1;

  pru_engine #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_take),
    .item      (in_if.data),
    .mode      (mode_r),
    .idle      (eng_idle),
    .res_valid (eng_res_valid),
    .res       (eng_res),
    .res_ack   (eng_res_ack)
  );

  // Result register: loads when empty or being drained
  assign eng_res_ack   = eng_res_valid && (!out_valid_r || out_if.ready);
  assign out_valid_nxt = eng_res_ack || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      mode_r      <= pru_pkg::MODE_FIFO;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid) begin
        mode_r <= cfg_if.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eng_res_ack) begin
      out_data_r <= eng_res;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

endmodule

`default_nettype wire
